[hdl/assert_macros.svh]
// Assertion macros used by the stream hash top.
// Checks compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define XXH_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
`define XXH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define XXH_ASSERT(lbl, clk, rst, prop)
`define XXH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/xxh_pkg.sv]
// Shared constants, micro-op codes and controller/datapath interface types
// for the 64-bit stream hash. No dependencies.
`default_nettype none
package xxh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  // multiply micro-ops
  localparam logic [3:0] OP_LANE1  = 4'd0;
  localparam logic [3:0] OP_LANE2  = 4'd1;
  localparam logic [3:0] OP_MERGE1 = 4'd2;
  localparam logic [3:0] OP_MERGE2 = 4'd3;
  localparam logic [3:0] OP_MERGE3 = 4'd4;
  localparam logic [3:0] OP_T8_1   = 4'd5;
  localparam logic [3:0] OP_T8_2   = 4'd6;
  localparam logic [3:0] OP_T8_3   = 4'd7;
  localparam logic [3:0] OP_T4_1   = 4'd8;
  localparam logic [3:0] OP_T4_2   = 4'd9;
  localparam logic [3:0] OP_B1     = 4'd10;
  localparam logic [3:0] OP_B2     = 4'd11;
  localparam logic [3:0] OP_AV1    = 4'd12;
  localparam logic [3:0] OP_AV2    = 4'd13;

  typedef struct packed {
    logic       load;
    logic       insert;
    logic       stripe_done;
    logic       mul_start;
    logic       wb;
    logic       h_init;
    logic       h_len;
    logic       out_load;
    logic [3:0] op;
    logic [1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic       ins_full;
    logic       last;
    logic       seen;
    logic [4:0] tail_rem;
    logic       mul_done;
  } sts_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage
`default_nettype wire

[hdl/xxh64_stream_hash_top.sv]
// Stream hash top: takes one input word and inserts it into the stripe buffer before
// accepting the next. Each full 32-byte stripe runs one round per lane; every 64-bit
// multiply uses one shared 32x32 multiplier. Last word: h init, merge if a stripe was
// seen, length add, tail 8-byte words, a 4-byte word, bytes, avalanche, output register.
// The output register frees the input side while a result waits.
// Synchronous active-high reset clears control state and the seed to zero.
`default_nettype none
`include "assert_macros.svh"
module xxh64_stream_hash_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic [63:0]  cfg_wr_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [71:0]  s_axis_tdata,  // data_word[63:0], byte_count[67:64], zero pad
  input  wire logic         s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic      [127:0] m_axis_tdata   // hash_value[63:0], message_length[127:64]
);

  xxh_pkg::cmd_t cmd;
  xxh_pkg::sts_t sts;
  logic [63:0]   hash_out;
  logic [63:0]   len_out;
  logic          out_free;
  logic [7:0]    cmd_strobes;

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cmd_strobes = {cmd.load, cmd.insert, cmd.stripe_done, cmd.mul_start,
                        cmd.wb, cmd.h_init, cmd.h_len, cmd.out_load};

  xxh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  xxh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_axis_tdata[63:0]),
    .in_count    (s_axis_tdata[67:64]),
    .in_last     (s_axis_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .hash_out    (hash_out),
    .len_out     (len_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_axis_tdata <= {len_out, hash_out};
    end
  end

  `XXH_ASSERT(a_no_overwrite, clk, rst, !cmd.out_load || out_free)
  `XXH_ASSERT_NEXT(a_busy_after_req, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `XXH_ASSERT(a_one_cmd, clk, rst, $onehot0(cmd_strobes))

endmodule
`default_nettype wire

[hdl/xxh_mul.sv]
// Multi-cycle 64x64 low-half multiplier built on one shared 32x32 multiplier.
// Uses no package items.
`default_nettype none
module xxh_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic      [63:0] prod,
  output logic             done
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] opx;
  logic [31:0] opy;
  logic [63:0] pp;

  always_comb begin
    case (step)
      2'd0: begin
        opx = a_r[31:0];
        opy = b_r[31:0];
      end
      2'd1: begin
        opx = a_r[31:0];
        opy = b_r[63:32];
      end
      default: begin
        opx = a_r[63:32];
        opy = b_r[31:0];
      end
    endcase
  end

  assign pp = opx * opy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy) begin
      if (step == 2'd0) begin
        prod <= pp;
      end else begin
        // cross products only reach the upper half
        prod <= prod + {pp[31:0], 32'd0};
      end
    end
  end

endmodule
`default_nettype wire

[hdl/xxh_dp.sv]
// Datapath: seed, lane accumulators, stripe buffer, counters and hash register.
// Depends on xxh_pkg and xxh_mul.
`default_nettype none
module xxh_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic   [63:0] cfg_wr_data,
  input  wire logic   [63:0] in_data,
  input  wire logic   [3:0]  in_count,
  input  wire logic          in_last,
  input  wire xxh_pkg::cmd_t cmd,
  output xxh_pkg::sts_t      sts,
  output logic        [63:0] hash_out,
  output logic        [63:0] len_out
);

  logic [63:0]  seed;
  logic [63:0]  acc [4];
  logic [255:0] sbuf;
  logic [4:0]   buf_cnt;
  logic [63:0]  total;
  logic         seen;
  logic         in_msg;
  logic [63:0]  wrd;
  logic [3:0]   rem;
  logic         last;
  logic [63:0]  t;
  logic [63:0]  h;
  logic [4:0]   pos;

  logic         full;
  logic [5:0]   k;
  logic [255:0] sbuf_next;
  logic [255:0] tail;
  logic [63:0]  mul_a;
  logic [63:0]  mul_k;
  logic [63:0]  mul_p;
  logic         mul_done;
  logic [63:0]  rotsum;
  logic [63:0]  hx;

  assign full = ({2'b0, rem} + {1'b0, buf_cnt}) >= 6'd32;
  assign k    = full ? (6'd32 - {1'b0, buf_cnt}) : {2'b0, rem};

  always_comb begin
    logic [4:0] off;
    logic       in_rng;
    for (int j = 0; j < 32; j++) begin
      off    = 5'(j) - buf_cnt;
      in_rng = (5'(j) >= buf_cnt) && (6'(j) < ({1'b0, buf_cnt} + k));
      sbuf_next[j*8 +: 8] = in_rng ? wrd[{off[2:0], 3'b000} +: 8] : sbuf[j*8 +: 8];
    end
  end

  assign tail   = sbuf >> {pos, 3'b000};
  assign hx     = h ^ t;
  assign rotsum = xxh_pkg::rotl64(acc[0], 1) + xxh_pkg::rotl64(acc[1], 7)
                + xxh_pkg::rotl64(acc[2], 12) + xxh_pkg::rotl64(acc[3], 18);

  always_comb begin
    case (cmd.op)
      xxh_pkg::OP_LANE1: begin
        mul_a = sbuf[{cmd.lane, 6'd0} +: 64];
        mul_k = xxh_pkg::P2;
      end
      xxh_pkg::OP_LANE2: begin
        mul_a = xxh_pkg::rotl64(acc[cmd.lane] + t, 31);
        mul_k = xxh_pkg::P1;
      end
      xxh_pkg::OP_MERGE1: begin
        mul_a = acc[cmd.lane];
        mul_k = xxh_pkg::P2;
      end
      xxh_pkg::OP_MERGE2, xxh_pkg::OP_T8_2: begin
        mul_a = xxh_pkg::rotl64(t, 31);
        mul_k = xxh_pkg::P1;
      end
      xxh_pkg::OP_MERGE3: begin
        mul_a = hx;
        mul_k = xxh_pkg::P1;
      end
      xxh_pkg::OP_T8_1: begin
        mul_a = sbuf[{pos[4:3], 6'd0} +: 64];
        mul_k = xxh_pkg::P2;
      end
      xxh_pkg::OP_T8_3: begin
        mul_a = xxh_pkg::rotl64(hx, 27);
        mul_k = xxh_pkg::P1;
      end
      xxh_pkg::OP_T4_1: begin
        mul_a = {32'd0, tail[31:0]};
        mul_k = xxh_pkg::P1;
      end
      xxh_pkg::OP_T4_2: begin
        mul_a = xxh_pkg::rotl64(hx, 23);
        mul_k = xxh_pkg::P2;
      end
      xxh_pkg::OP_B1: begin
        mul_a = {56'd0, tail[7:0]};
        mul_k = xxh_pkg::P5;
      end
      xxh_pkg::OP_B2: begin
        mul_a = xxh_pkg::rotl64(hx, 11);
        mul_k = xxh_pkg::P1;
      end
      xxh_pkg::OP_AV1: begin
        mul_a = h ^ (h >> 33);
        mul_k = xxh_pkg::P2;
      end
      xxh_pkg::OP_AV2: begin
        mul_a = h ^ (h >> 29);
        mul_k = xxh_pkg::P3;
      end
      default: begin
        mul_a = h;
        mul_k = xxh_pkg::P1;
      end
    endcase
  end

  xxh_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_k),
    .prod  (mul_p),
    .done  (mul_done)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed    <= 64'd0;
      buf_cnt <= 5'd0;
      total   <= 64'd0;
      seen    <= 1'b0;
      in_msg  <= 1'b0;
      rem     <= 4'd0;
      last    <= 1'b0;
      pos     <= 5'd0;
    end else begin
      if (cfg_wr_en) begin
        seed <= cfg_wr_data;
      end
      if (cmd.load) begin
        rem  <= (in_count > 4'd8) ? 4'd8 : in_count;
        last <= in_last;
        if (!in_msg) begin
          buf_cnt <= 5'd0;
          total   <= 64'd0;
          seen    <= 1'b0;
          in_msg  <= 1'b1;
        end
      end
      if (cmd.insert) begin
        buf_cnt <= buf_cnt + k[4:0];
        total   <= total + {58'd0, k};
        rem     <= rem - k[3:0];
      end
      if (cmd.stripe_done) begin
        seen <= 1'b1;
      end
      if (cmd.h_len) begin
        pos <= 5'd0;
      end
      if (cmd.wb) begin
        case (cmd.op)
          xxh_pkg::OP_T8_3: pos <= pos + 5'd8;
          xxh_pkg::OP_T4_2: pos <= pos + 5'd4;
          xxh_pkg::OP_B2:   pos <= pos + 5'd1;
          default:          pos <= pos;
        endcase
      end
      if (cmd.out_load) begin
        in_msg <= 1'b0;
      end
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wrd <= in_data;
      if (!in_msg) begin
        acc[0] <= seed + xxh_pkg::P1 + xxh_pkg::P2;
        acc[1] <= seed + xxh_pkg::P2;
        acc[2] <= seed;
        acc[3] <= seed - xxh_pkg::P1;
      end
    end
    if (cmd.insert) begin
      sbuf <= sbuf_next;
      wrd  <= wrd >> {k[3:0], 3'b000};
    end
    if (cmd.h_init) begin
      h <= seen ? rotsum : seed + xxh_pkg::P5;
    end
    if (cmd.h_len) begin
      h <= h + total;
    end
    if (cmd.wb) begin
      case (cmd.op)
        xxh_pkg::OP_LANE2:                   acc[cmd.lane] <= mul_p;
        xxh_pkg::OP_MERGE3, xxh_pkg::OP_T8_3: h <= mul_p + xxh_pkg::P4;
        xxh_pkg::OP_T4_2:                    h <= mul_p + xxh_pkg::P3;
        xxh_pkg::OP_B2, xxh_pkg::OP_AV1,
        xxh_pkg::OP_AV2:                     h <= mul_p;
        default:                             t <= mul_p;
      endcase
    end
  end

  assign sts.ins_full = full;
  assign sts.last     = last;
  assign sts.seen     = seen;
  assign sts.tail_rem = buf_cnt - pos;
  assign sts.mul_done = mul_done;

  assign hash_out = h ^ (h >> 32);
  assign len_out  = total;

endmodule
`default_nettype wire

[hdl/xxh_ctrl.sv]
// Controller state machine: sequences byte insertion, stripe rounds,
// finalization and output. Depends on xxh_pkg.
`default_nettype none
module xxh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          out_free,
  input  wire xxh_pkg::sts_t sts,
  output xxh_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INS    = 4'd1;
  localparam logic [3:0] S_STRIPE = 4'd2;
  localparam logic [3:0] S_ISSUE  = 4'd3;
  localparam logic [3:0] S_WAIT   = 4'd4;
  localparam logic [3:0] S_HINIT  = 4'd5;
  localparam logic [3:0] S_HLEN   = 4'd6;
  localparam logic [3:0] S_TAIL   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] op;
  logic [3:0] op_next;
  logic [1:0] lane;
  logic [1:0] lane_next;

  always_comb begin
    state_next = state;
    op_next    = op;
    lane_next  = lane;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.op     = op;
    cmd.lane   = lane;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.insert = 1'b1;
        if (sts.ins_full) begin
          op_next    = xxh_pkg::OP_LANE1;
          lane_next  = 2'd0;
          state_next = S_ISSUE;
        end else if (sts.last) begin
          state_next = S_HINIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_STRIPE: begin
        cmd.stripe_done = 1'b1;
        state_next      = S_INS;
      end
      S_ISSUE: begin
        cmd.mul_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (sts.mul_done) begin
          cmd.wb     = 1'b1;
          state_next = S_ISSUE;
          case (op)
            xxh_pkg::OP_LANE1:  op_next = xxh_pkg::OP_LANE2;
            xxh_pkg::OP_LANE2: begin
              if (lane == 2'd3) begin
                state_next = S_STRIPE;
              end else begin
                lane_next = lane + 2'd1;
                op_next   = xxh_pkg::OP_LANE1;
              end
            end
            xxh_pkg::OP_MERGE1: op_next = xxh_pkg::OP_MERGE2;
            xxh_pkg::OP_MERGE2: op_next = xxh_pkg::OP_MERGE3;
            xxh_pkg::OP_MERGE3: begin
              if (lane == 2'd3) begin
                state_next = S_HLEN;
              end else begin
                lane_next = lane + 2'd1;
                op_next   = xxh_pkg::OP_MERGE1;
              end
            end
            xxh_pkg::OP_T8_1:   op_next = xxh_pkg::OP_T8_2;
            xxh_pkg::OP_T8_2:   op_next = xxh_pkg::OP_T8_3;
            xxh_pkg::OP_T4_1:   op_next = xxh_pkg::OP_T4_2;
            xxh_pkg::OP_B1:     op_next = xxh_pkg::OP_B2;
            xxh_pkg::OP_AV1:    op_next = xxh_pkg::OP_AV2;
            xxh_pkg::OP_AV2:    state_next = S_OUT;
            default:            state_next = S_TAIL;
          endcase
        end
      end
      S_HINIT: begin
        cmd.h_init = 1'b1;
        if (sts.seen) begin
          op_next    = xxh_pkg::OP_MERGE1;
          lane_next  = 2'd0;
          state_next = S_ISSUE;
        end else begin
          state_next = S_HLEN;
        end
      end
      S_HLEN: begin
        cmd.h_len  = 1'b1;
        state_next = S_TAIL;
      end
      S_TAIL: begin
        state_next = S_ISSUE;
        if (sts.tail_rem >= 5'd8) begin
          op_next = xxh_pkg::OP_T8_1;
        end else if (sts.tail_rem >= 5'd4) begin
          op_next = xxh_pkg::OP_T4_1;
        end else if (sts.tail_rem != 5'd0) begin
          op_next = xxh_pkg::OP_B1;
        end else begin
          op_next = xxh_pkg::OP_AV1;
        end
      end
      S_OUT: begin
        // hold until the output register can take the result
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= xxh_pkg::OP_LANE1;
      lane  <= 2'd0;
    end else begin
      state <= state_next;
      op    <= op_next;
      lane  <= lane_next;
    end
  end

endmodule
`default_nettype wire
